// ===== sv/y2rgb_pkg.sv =====
// Shared types and constants for the YUY2 to RGB pixel pair converter.
// Word layouts, lane control and the BT.601 Q16 coefficients.
// No dependencies.
`timescale 1ns / 1ps

package y2rgb_pkg;

  // Product and sum widths, signed; the widest channel sum (blue) needs 27 bits
  localparam int PROD_W = 27;
  localparam int SUM_W  = 28;

  // Coefficients at 16 fractional bits
  localparam logic signed [PROD_W-1:0] COEF_Y   = PROD_W'(76284);
  localparam logic signed [PROD_W-1:0] COEF_RV  = PROD_W'(104595);
  localparam logic signed [PROD_W-1:0] COEF_GU  = PROD_W'(25690);
  localparam logic signed [PROD_W-1:0] COEF_GV  = PROD_W'(53281);
  localparam logic signed [PROD_W-1:0] COEF_BU  = PROD_W'(132186);
  localparam logic        [SUM_W-1:0]  HALF_Q16 = SUM_W'(32768);

  localparam logic signed [8:0] LUMA_OFS = 9'sd16;

  typedef struct packed {
    logic [7:0] luma_first;
    logic [7:0] blue_diff;
    logic [7:0] luma_second;
    logic [7:0] red_diff;
    logic       first_only;
  } y2rgb_in_t;

  typedef struct packed {
    logic [7:0] red_first;
    logic [7:0] green_first;
    logic [7:0] blue_first;
    logic [7:0] red_second;
    logic [7:0] green_second;
    logic [7:0] blue_second;
    logic       second_valid;
  } y2rgb_out_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // Load enables for the two lane stages
  typedef struct packed {
    logic load_prod;
    logic load_pix;
  } lane_ctl_t;

endpackage

// ===== sv/y2rgb_lane.sv =====
// One pixel conversion lane: coefficient products, then sum, round and clamp.
// Two register stages; enables come from the top level. Uses y2rgb_pkg.
`timescale 1ns / 1ps

module y2rgb_lane
  import y2rgb_pkg::*;
(
  input  logic       clk,
  input  lane_ctl_t  ctl,
  input  logic [7:0] luma,
  input  logic [7:0] blue_diff,
  input  logic [7:0] red_diff,
  output rgb_t       pix
);

  // Round half away from zero then clamp to 0..255; negatives always land on 0
  function automatic logic [7:0] round_sat(input logic signed [SUM_W-1:0] s);
    logic [SUM_W-1:0] t;
    logic [7:0]       v;
    t = SUM_W'(s) + HALF_Q16;
    if (s[SUM_W-1]) begin
      v = 8'd0;
    end else if (|t[SUM_W-1:24]) begin
      v = 8'hff;
    end else begin
      v = t[23:16];
    end
    return v;
  endfunction

  logic signed [8:0]        y_off;
  logic signed [7:0]        du;
  logic signed [7:0]        dv;
  logic signed [PROD_W-1:0] y_ext;
  logic signed [PROD_W-1:0] du_ext;
  logic signed [PROD_W-1:0] dv_ext;

  logic signed [PROD_W-1:0] ly_r, rv_r, gu_r, gv_r, bu_r;
  logic signed [SUM_W-1:0]  sum_r, sum_g, sum_b;
  rgb_t                     pix_r;

  assign y_off  = $signed({1'b0, luma}) - LUMA_OFS;
  // offset-128 sample to two's complement: flip the top bit
  assign du     = $signed({~blue_diff[7], blue_diff[6:0]});
  assign dv     = $signed({~red_diff[7], red_diff[6:0]});
  assign y_ext  = PROD_W'(y_off);
  assign du_ext = PROD_W'(du);
  assign dv_ext = PROD_W'(dv);

  always_ff @(posedge clk) begin
    if (ctl.load_prod) begin
      ly_r <= y_ext * COEF_Y;
      rv_r <= dv_ext * COEF_RV;
      gu_r <= du_ext * COEF_GU;
      gv_r <= dv_ext * COEF_GV;
      bu_r <= du_ext * COEF_BU;
    end
  end

  assign sum_r = SUM_W'(ly_r) + SUM_W'(rv_r);
  assign sum_g = SUM_W'(ly_r) - SUM_W'(gu_r) - SUM_W'(gv_r);
  assign sum_b = SUM_W'(ly_r) + SUM_W'(bu_r);

  always_ff @(posedge clk) begin
    if (ctl.load_pix) begin
      pix_r.red   <= round_sat(sum_r);
      pix_r.green <= round_sat(sum_g);
      pix_r.blue  <= round_sat(sum_b);
    end
  end

  assign pix = pix_r;

endmodule

// ===== sv/y2rgb_merge.sv =====
// Merge stage: joins both lane pixels into the result word, blanks the odd tail.
// Doubles as the output register. Uses y2rgb_pkg.
`timescale 1ns / 1ps

module y2rgb_merge
  import y2rgb_pkg::*;
(
  input  logic       clk,
  input  logic       load,
  input  rgb_t       pix_first,
  input  rgb_t       pix_second,
  input  logic       first_only,
  output y2rgb_out_t out_word
);

  y2rgb_out_t word_r;
  y2rgb_out_t word_nxt;

  always_comb begin
    word_nxt.red_first    = pix_first.red;
    word_nxt.green_first  = pix_first.green;
    word_nxt.blue_first   = pix_first.blue;
    word_nxt.second_valid = ~first_only;
    if (first_only) begin
      word_nxt.red_second   = 8'd0;
      word_nxt.green_second = 8'd0;
      word_nxt.blue_second  = 8'd0;
    end else begin
      word_nxt.red_second   = pix_second.red;
      word_nxt.green_second = pix_second.green;
      word_nxt.blue_second  = pix_second.blue;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word_r <= word_nxt;
    end
  end

  assign out_word = word_r;

endmodule

// ===== sv/yuy2_to_rgb_pixel_pair_core.sv =====
// Top level of the YUY2 macropixel to RGB pixel pair converter (BT.601 studio range).
// Two y2rgb_lane instances and a y2rgb_merge stage, with the pipeline valid chain.
// Uses y2rgb_pkg.
//
//   channel | ports                      | word
//   --------+----------------------------+-------------
//   input   | in_valid, in_stall, in_word  | y2rgb_in_t
//   result  | out_valid, out_stall, out_word | y2rgb_out_t
//
// Three register stages: products, rounded pixels, merged result word.
// One word accepted per cycle while in_stall is low; it passes the product, pixel and result registers to out_valid.
// Each stage loads when empty or when the stage after it moves, so bubbles close up.
// in_stall rises only with all three stages full and out_stall high.
// Reset empties the pipeline; payload registers are not reset.
`timescale 1ns / 1ps

module yuy2_to_rgb_pixel_pair_core
  import y2rgb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  y2rgb_in_t  in_word,
  output logic       out_valid,
  input  logic       out_stall,
  output y2rgb_out_t out_word
);

  logic      v1_r, v2_r, v3_r;
  logic      v1_nxt, v2_nxt, v3_nxt;
  logic      rdy1, rdy2, rdy3;
  logic      tail1_r, tail2_r;
  lane_ctl_t lane_ctl;
  rgb_t      pix_first, pix_second;

  assign rdy3 = ~v3_r | ~out_stall;
  assign rdy2 = ~v2_r | rdy3;
  assign rdy1 = ~v1_r | rdy2;

  assign v1_nxt = rdy1 ? in_valid : v1_r;
  assign v2_nxt = rdy2 ? v1_r     : v2_r;
  assign v3_nxt = rdy3 ? v2_r     : v3_r;

  assign lane_ctl.load_prod = rdy1 & in_valid;
  assign lane_ctl.load_pix  = rdy2 & v1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  // tail flag follows the word down the pipe
  always_ff @(posedge clk) begin
    if (lane_ctl.load_prod) begin
      tail1_r <= in_word.first_only;
    end
    if (lane_ctl.load_pix) begin
      tail2_r <= tail1_r;
    end
  end

  y2rgb_lane u_lane_first (
    .clk       (clk),
    .ctl       (lane_ctl),
    .luma      (in_word.luma_first),
    .blue_diff (in_word.blue_diff),
    .red_diff  (in_word.red_diff),
    .pix       (pix_first)
  );

  y2rgb_lane u_lane_second (
    .clk       (clk),
    .ctl       (lane_ctl),
    .luma      (in_word.luma_second),
    .blue_diff (in_word.blue_diff),
    .red_diff  (in_word.red_diff),
    .pix       (pix_second)
  );

  y2rgb_merge u_merge (
    .clk        (clk),
    .load       (rdy3 & v2_r),
    .pix_first  (pix_first),
    .pix_second (pix_second),
    .first_only (tail2_r),
    .out_word   (out_word)
  );

  assign in_stall  = ~rdy1;
  assign out_valid = v3_r;

`ifndef SYNTHESIS
  a_reset_empty : assert property (@(posedge clk)
    !rst_n |=> !v1_r && !v2_r && !out_valid)
    else $error("pipeline not empty after reset");

  a_stall_full : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> v1_r && v2_r && out_valid && out_stall)
    else $error("input stalled with room in the pipeline");

  a_advance : assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && !out_stall |=> out_valid)
    else $error("pixel stage word lost on its way out");

  a_tail_blank : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.second_valid |->
      out_word.red_second == 8'd0 && out_word.green_second == 8'd0 &&
      out_word.blue_second == 8'd0)
    else $error("odd tail word carries a second pixel");
`endif

endmodule

// ===== test/yuy2_to_rgb_pixel_pair_core_tb.sv =====
// Self-checking testbench for yuy2_to_rgb_pixel_pair_core (BT.601 YUY2 to RGB pair).
// Predicts each result word in Q16 fixed point; checks in order under random idling.
// Depends on y2rgb_pkg and the core RTL.
`timescale 1ns / 1ps

module yuy2_to_rgb_pixel_pair_core_tb
  import y2rgb_pkg::*;
();

  localparam longint Q_LUMA   = 76284;
  localparam longint Q_RED_V  = 104595;
  localparam longint Q_GRN_U  = 25690;
  localparam longint Q_GRN_V  = 53281;
  localparam longint Q_BLU_U  = 132186;
  localparam longint Q_HALF   = 32768;
  localparam int     CYCLE_LIMIT = 200000;
  localparam int     DRAIN_CYCLES = 8;
  localparam int     RANDOM_WORDS = 750;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  y2rgb_in_t  in_word = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  y2rgb_out_t out_word;

  y2rgb_out_t pending_rgb[$];
  int         err_cnt = 0;
  int         words_sent = 0;
  int         tails_sent = 0;
  int         pairs_checked = 0;
  int         cycle_cnt = 0;
  int         hold_left = 0;
  bit         gaps_on = 1'b0;
  bit         stalls_on = 1'b0;

  yuy2_to_rgb_pixel_pair_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("yuy2_to_rgb_pixel_pair_core test failed");
    $finish;
  end

  // Round half away from zero, then clamp to 0..255
  function automatic logic [7:0] round_clamp(longint s);
    longint v;
    if (s >= 0) begin
      v = (s + Q_HALF) / 65536;
    end else begin
      v = -((-s + Q_HALF) / 65536);
    end
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  function automatic rgb_t pixel_rgb(logic [7:0] y, longint du, longint dv);
    rgb_t   p;
    longint ly;
    ly = (longint'(y) - 16) * Q_LUMA;
    p.red   = round_clamp(ly + Q_RED_V * dv);
    p.green = round_clamp(ly - Q_GRN_U * du - Q_GRN_V * dv);
    p.blue  = round_clamp(ly + Q_BLU_U * du);
    return p;
  endfunction

  function automatic y2rgb_out_t predict_rgb_pair(y2rgb_in_t w);
    y2rgb_out_t r;
    rgb_t       p0;
    rgb_t       p1;
    longint     du;
    longint     dv;
    du = longint'(w.blue_diff) - 128;
    dv = longint'(w.red_diff) - 128;
    p0 = pixel_rgb(w.luma_first, du, dv);
    p1 = pixel_rgb(w.luma_second, du, dv);
    r.red_first   = p0.red;
    r.green_first = p0.green;
    r.blue_first  = p0.blue;
    if (w.first_only) begin
      r.red_second   = '0;
      r.green_second = '0;
      r.blue_second  = '0;
      r.second_valid = 1'b0;
    end else begin
      r.red_second   = p1.red;
      r.green_second = p1.green;
      r.blue_second  = p1.blue;
      r.second_valid = 1'b1;
    end
    return r;
  endfunction

  // Offer one word, wait for acceptance, then maybe leave a gap
  task automatic send_word(y2rgb_in_t w);
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_rgb.push_back(predict_rgb_pair(w));
    words_sent++;
    if (w.first_only) tails_sent++;
    if (gaps_on && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic send_fields(int y0, int u, int y1, int v, bit tail);
    y2rgb_in_t w;
    w.luma_first  = y0[7:0];
    w.blue_diff   = u[7:0];
    w.luma_second = y1[7:0];
    w.red_diff    = v[7:0];
    w.first_only  = tail;
    send_word(w);
  endtask

  // Mostly uniform, with the rails picked now and then
  function automatic logic [7:0] pick_sample();
    int r;
    r = $urandom_range(99);
    if (r < 5) return 8'd0;
    if (r < 10) return 8'd255;
    return 8'($urandom_range(255));
  endfunction

  task automatic test_extremes();
    send_fields(0, 0, 0, 0, 1'b0);
    send_fields(255, 255, 255, 255, 1'b0);
    send_fields(16, 128, 235, 128, 1'b0);   // black and white
    send_fields(0, 128, 255, 128, 1'b0);
    send_fields(0, 0, 255, 255, 1'b0);
    send_fields(255, 0, 0, 255, 1'b0);
    send_fields(128, 255, 128, 0, 1'b0);
    send_fields(81, 90, 145, 240, 1'b0);    // near saturated red
    send_fields(41, 240, 210, 110, 1'b0);   // near saturated blue
    send_fields(16, 127, 17, 129, 1'b0);    // tiny chroma, rounding near zero
    send_fields(170, 85, 85, 170, 1'b0);
    send_fields(235, 16, 16, 240, 1'b0);
  endtask

  // Odd row tail: second lane forced to zero whatever luma_second holds
  task automatic test_odd_tail();
    send_fields(0, 0, 255, 0, 1'b1);
    send_fields(255, 255, 0, 255, 1'b1);
    send_fields(16, 128, 170, 128, 1'b1);
    send_fields(235, 0, 85, 255, 1'b1);
    send_fields(128, 255, 255, 0, 1'b1);
  endtask

  task automatic test_random_words(int n);
    y2rgb_in_t w;
    for (int i = 0; i < n; i++) begin
      w.luma_first  = pick_sample();
      w.blue_diff   = pick_sample();
      w.luma_second = pick_sample();
      w.red_diff    = pick_sample();
      w.first_only  = ($urandom_range(99) < 12);
      send_word(w);
    end
  endtask

  task automatic test_full_rate(int n);
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    test_random_words(n);
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  // Receiver holds off long enough for the pipeline to fill and stall its input
  task automatic test_backpressure();
    hold_left = 80;
    test_random_words(40);
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= stalls_on && ($urandom_range(99) < 15);
      end
    end
  end

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin : check_results
    y2rgb_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_rgb.size() == 0) begin
        $error("result word with nothing pending");
        err_cnt++;
      end else begin
        want = pending_rgb.pop_front();
        check_field("red_first",    want.red_first,    out_word.red_first);
        check_field("green_first",  want.green_first,  out_word.green_first);
        check_field("blue_first",   want.blue_first,   out_word.blue_first);
        check_field("red_second",   want.red_second,   out_word.red_second);
        check_field("green_second", want.green_second, out_word.green_second);
        check_field("blue_second",  want.blue_second,  out_word.blue_second);
        check_field("second_valid", want.second_valid, out_word.second_valid);
        pairs_checked++;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_odd_tail();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    test_random_words(RANDOM_WORDS / 2);
    test_backpressure();
    test_full_rate(150);
    test_random_words(RANDOM_WORDS / 2 - 190);
    in_valid <= 1'b0;
    while (pending_rgb.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d macropixels (%0d odd-row tails), checked %0d pixel pairs,",
             words_sent, tails_sent, pairs_checked);
    $display("covering rail values, a long receiver hold and a stretch at full rate.");
    if (err_cnt == 0) begin
      $display("yuy2_to_rgb_pixel_pair_core test passed");
    end else begin
      $display("yuy2_to_rgb_pixel_pair_core test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/y2rgb_pkg.sv
sv/y2rgb_lane.sv
sv/y2rgb_merge.sv
sv/yuy2_to_rgb_pixel_pair_core.sv
test/yuy2_to_rgb_pixel_pair_core_tb.sv
